/* sv/mprr_pkg.sv */
// Shared constants, types and codes of the multilevel priority round-robin scheduler.
`default_nettype none
package mprr_pkg;

  // Scheduler geometry.
  localparam int NUM_LEVELS  = 5;
  localparam int LEVEL_DEPTH = 16;
  localparam int ID_WIDTH    = 8;

  // Derived widths.
  localparam int FILL_W    = $clog2(LEVEL_DEPTH + 1);
  localparam int LVL_IDX_W = $clog2(NUM_LEVELS);
  localparam int TOTAL_W   = 7;

  // Fixed widths of the item fields.
  localparam int REQ_W     = 2;
  localparam int TASK_ID_W = 8;
  localparam int TASK_LV_W = 3;
  localparam int STATUS_W  = 2;

  typedef logic [ID_WIDTH-1:0]  id_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [LVL_IDX_W-1:0] lvl_idx_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [TASK_ID_W-1:0] task_id_t;
  typedef logic [TASK_LV_W-1:0] task_level_t;

  // Request codes; the fourth code is not a valid request.
  localparam req_t REQ_ENQUEUE = 2'd0;
  localparam req_t REQ_REMOVE  = 2'd1;
  localparam req_t REQ_SELECT  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FIN
  } state_t;

  // Operation applied to one level chain in a cycle.
  typedef enum logic [1:0] {
    LV_HOLD,
    LV_APPEND,
    LV_ROTATE,
    LV_DROP
  } level_op_t;

  typedef struct packed {
    level_op_t op;
    id_t       data;
  } level_cmd_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/mprr_if.sv */
// Item channel interfaces of the scheduler: request channel and result channel.
`default_nettype none
interface mprr_in_if;
  logic                   valid;
  logic                   ready;
  mprr_pkg::req_t         req_type;
  mprr_pkg::task_id_t     task_id;
  mprr_pkg::task_level_t  task_level;
  logic                   task_ready;
  logic                   skip_state_check;

  modport source (
    output valid, req_type, task_id, task_level, task_ready, skip_state_check,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_id, task_level, task_ready, skip_state_check,
    output ready
  );
endinterface

interface mprr_out_if;
  logic                          valid;
  logic                          ready;
  logic [mprr_pkg::STATUS_W-1:0] status;
  logic                          picked_valid;
  mprr_pkg::task_id_t            picked_id;
  mprr_pkg::task_level_t         picked_level;
  mprr_pkg::total_t              total_tasks;

  modport source (
    output valid, status, picked_valid, picked_id, picked_level, total_tasks,
    input  ready
  );
  modport sink (
    input  valid, status, picked_valid, picked_id, picked_level, total_tasks,
    output ready
  );
endinterface
`default_nettype wire

/* sv/mprr_cell.sv */
// One queue cell: holds one task identifier and takes its right neighbor's on a shift.
`default_nettype none
module mprr_cell (
  input  wire                  clk,
  input  mprr_pkg::cell_ctrl_t ctrl,
  input  mprr_pkg::id_t        load_data,
  input  mprr_pkg::id_t        right_data,
  output mprr_pkg::id_t        value
);

  // A load wins over a shift; otherwise the cell holds.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= load_data;
    end else if (ctrl.shift) begin
      value <= right_data;
    end
  end

endmodule
`default_nettype wire

/* sv/mprr_level.sv */
// One priority level: a chain of cells in queue order with its head in cell zero.
`default_nettype none
module mprr_level (
  input  wire                    clk,
  input  wire                    rst,
  input  mprr_pkg::level_cmd_t   cmd,
  output mprr_pkg::id_t          head,
  output mprr_pkg::fill_t        fill
);

  mprr_pkg::id_t value [mprr_pkg::LEVEL_DEPTH];

  logic moving;
  assign moving = (cmd.op == mprr_pkg::LV_ROTATE) || (cmd.op == mprr_pkg::LV_DROP);
  assign head   = value[0];

  // Each cell shifts left while inside the occupied part; the tail cell takes the
  // appended item or, on a rotate, the old head.
  for (genvar k = 0; k < mprr_pkg::LEVEL_DEPTH; k++) begin : g_cell
    localparam mprr_pkg::fill_t KF = mprr_pkg::fill_t'(k);
    localparam mprr_pkg::fill_t KN = mprr_pkg::fill_t'(k + 1);

    mprr_pkg::cell_ctrl_t ctrl;
    mprr_pkg::id_t        load_data;
    mprr_pkg::id_t        right_data;

    assign ctrl.shift = moving && (KN < fill);
    assign ctrl.load  = ((cmd.op == mprr_pkg::LV_APPEND) && (KF == fill)) ||
                        ((cmd.op == mprr_pkg::LV_ROTATE) && (KN == fill));
    assign load_data  = (cmd.op == mprr_pkg::LV_APPEND) ? cmd.data : value[0];

    if (k == mprr_pkg::LEVEL_DEPTH - 1) begin : g_last
      assign right_data = value[k];
    end else begin : g_mid
      assign right_data = value[k + 1];
    end

    mprr_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_data  (load_data),
      .right_data (right_data),
      .value      (value[k])
    );
  end

  // Occupancy of this level.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      unique case (cmd.op)
        mprr_pkg::LV_APPEND: fill <= fill + 1'b1;
        mprr_pkg::LV_DROP:   fill <= fill - 1'b1;
        mprr_pkg::LV_HOLD,
        mprr_pkg::LV_ROTATE: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/multilevel_priority_round_robin_top.sv */
// Multilevel priority round-robin task scheduler: control sequencer and level chains.
//
// Requests arrive on in_ch and each produces exactly one result item on out_ch.
// Enqueue appends a task to its level, remove deletes the first matching task of
// its level, select returns the head of the lowest nonempty level and rotates it
// to that level's tail. Every result carries the total number of queued tasks.
// Each level is a chain of cells in queue order; every occupied cell behind the
// head hands its identifier to its left neighbor when the chain moves.
// An item is accepted only when the sequencer is idle. Enqueue, select and
// rejected requests load the result register from the execute state and then
// return to idle. A remove walks its level one cell per cycle, then loads the
// result from the finish state; the next item can be accepted only once the
// result of the last one is loaded, so items are taken one at a time.
// The result register lets the next item be accepted while a result still waits;
// a stalled receiver holds that item in the sequencer until the register frees.
// Synchronous reset empties every level and drops any pending result; no
// clearing pass is needed.
`default_nettype none
module multilevel_priority_round_robin_top (
  input  wire          clk,
  input  wire          rst,
  mprr_in_if.sink      in_ch,
  mprr_out_if.source   out_ch
);

  // Level chains.
  mprr_pkg::level_cmd_t cmd   [mprr_pkg::NUM_LEVELS];
  mprr_pkg::id_t        heads [mprr_pkg::NUM_LEVELS];
  mprr_pkg::fill_t      fills [mprr_pkg::NUM_LEVELS];

  for (genvar i = 0; i < mprr_pkg::NUM_LEVELS; i++) begin : g_level
    mprr_level u_level (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd[i]),
      .head (heads[i]),
      .fill (fills[i])
    );
  end

  // Sequencer registers.
  mprr_pkg::state_t      state, state_next;
  mprr_pkg::req_t        req_q;
  mprr_pkg::id_t         id_q;
  mprr_pkg::task_level_t lvl_q;
  logic                  ready_q;
  logic                  skip_q;
  mprr_pkg::fill_t       steps, steps_next;
  logic                  found, found_next;
  mprr_pkg::total_t      total, total_next;

  // Result register.
  logic                  out_valid;
  logic                  out_load;
  mprr_pkg::status_t     out_status, out_status_n;
  logic                  out_pv, out_pv_n;
  mprr_pkg::task_id_t    out_pid, out_pid_n;
  mprr_pkg::task_level_t out_plv, out_plv_n;
  mprr_pkg::total_t      out_total;

  logic               in_fire;
  logic               out_free;
  logic               lvl_ok;
  mprr_pkg::lvl_idx_t lvl_idx;
  logic               sel_found;
  mprr_pkg::lvl_idx_t sel_idx;
  logic               drop;

  assign in_ch.ready = (state == mprr_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  assign lvl_ok  = (lvl_q != '0) && (int'(lvl_q) < mprr_pkg::NUM_LEVELS);
  assign lvl_idx = mprr_pkg::lvl_idx_t'(lvl_q);
  assign drop    = !found && (heads[lvl_idx] == id_q);

  // Lowest nonempty level for a select.
  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    for (int i = mprr_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (fills[i] != '0) begin
        sel_found = 1'b1;
        sel_idx   = mprr_pkg::lvl_idx_t'(i);
      end
    end
  end

  // Next state, level commands and result.
  always_comb begin
    state_next   = state;
    steps_next   = steps;
    found_next   = found;
    total_next   = total;
    out_load     = 1'b0;
    out_status_n = mprr_pkg::ST_OK;
    out_pv_n     = 1'b0;
    out_pid_n    = '0;
    out_plv_n    = '0;
    for (int i = 0; i < mprr_pkg::NUM_LEVELS; i++) begin
      cmd[i].op   = mprr_pkg::LV_HOLD;
      cmd[i].data = id_q;
    end

    unique case (state)
      mprr_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = mprr_pkg::S_EXEC;
        end
      end

      mprr_pkg::S_EXEC: begin
        if (out_free) begin
          unique case (req_q)
            mprr_pkg::REQ_ENQUEUE: begin
              out_load   = 1'b1;
              state_next = mprr_pkg::S_IDLE;
              if ((!ready_q && !skip_q) || !lvl_ok) begin
                out_status_n = mprr_pkg::ST_INVALID;
              end else if (fills[lvl_idx] ==
                           mprr_pkg::fill_t'(mprr_pkg::LEVEL_DEPTH)) begin
                out_status_n = mprr_pkg::ST_FULL;
              end else begin
                cmd[lvl_idx].op = mprr_pkg::LV_APPEND;
                total_next      = total + 1'b1;
              end
            end

            mprr_pkg::REQ_REMOVE: begin
              if ((ready_q && !skip_q) || !lvl_ok) begin
                out_load     = 1'b1;
                out_status_n = mprr_pkg::ST_INVALID;
                state_next   = mprr_pkg::S_IDLE;
              end else if (fills[lvl_idx] == '0) begin
                out_load     = 1'b1;
                out_status_n = mprr_pkg::ST_ABSENT;
                state_next   = mprr_pkg::S_IDLE;
              end else begin
                steps_next = fills[lvl_idx];
                found_next = 1'b0;
                state_next = mprr_pkg::S_WALK;
              end
            end

            mprr_pkg::REQ_SELECT: begin
              out_load   = 1'b1;
              state_next = mprr_pkg::S_IDLE;
              if (sel_found) begin
                cmd[sel_idx].op = mprr_pkg::LV_ROTATE;
                out_pv_n        = 1'b1;
                out_pid_n       = mprr_pkg::task_id_t'(heads[sel_idx]);
                out_plv_n       = mprr_pkg::task_level_t'(sel_idx);
              end
            end

            default: begin
              out_load     = 1'b1;
              out_status_n = mprr_pkg::ST_INVALID;
              state_next   = mprr_pkg::S_IDLE;
            end
          endcase
        end
      end

      // Pass every task of the level through the head once, dropping the first match.
      mprr_pkg::S_WALK: begin
        if (drop) begin
          cmd[lvl_idx].op = mprr_pkg::LV_DROP;
          found_next      = 1'b1;
          total_next      = total - 1'b1;
        end else begin
          cmd[lvl_idx].op = mprr_pkg::LV_ROTATE;
        end
        steps_next = steps - 1'b1;
        if (steps == mprr_pkg::fill_t'(1)) begin
          state_next = mprr_pkg::S_FIN;
        end
      end

      mprr_pkg::S_FIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_n = found ? mprr_pkg::ST_OK : mprr_pkg::ST_ABSENT;
          state_next   = mprr_pkg::S_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mprr_pkg::S_IDLE;
      total     <= '0;
      found     <= 1'b0;
      steps     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      found <= found_next;
      steps <= steps_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_q   <= in_ch.req_type;
      id_q    <= mprr_pkg::id_t'(in_ch.task_id);
      lvl_q   <= in_ch.task_level;
      ready_q <= in_ch.task_ready;
      skip_q  <= in_ch.skip_state_check;
    end
    if (out_load) begin
      out_status <= out_status_n;
      out_pv     <= out_pv_n;
      out_pid    <= out_pid_n;
      out_plv    <= out_plv_n;
      out_total  <= total_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.picked_valid = out_pv;
  assign out_ch.picked_id    = out_pid;
  assign out_ch.picked_level = out_plv;
  assign out_ch.total_tasks  = out_total;

`ifndef SYNTH
  // Only a remove request walks a level.
  a_walk_is_remove: assert property (@(posedge clk) disable iff (rst)
    (state == mprr_pkg::S_WALK) |-> (req_q == mprr_pkg::REQ_REMOVE && lvl_ok))
    else $error("level walk without a valid remove request");

  // An accepted item enters the execute state in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == mprr_pkg::S_EXEC))
    else $error("accepted item not executed");

  // The most urgent level is never filled.
  a_level0_empty: assert property (@(posedge clk) disable iff (rst)
    fills[0] == '0)
    else $error("level zero holds tasks");

  // A walk never runs past the occupied cells.
  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    (state == mprr_pkg::S_WALK) |-> (steps != '0 && steps <= fills[lvl_idx] + found))
    else $error("walk step count out of range");

  // A result is never overwritten while the receiver stalls.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
